// ===== rtl/look_at_pitch_yaw_unit_macros.svh =====
// look_at_pitch_yaw_unit_macros.svh: assertion shorthands for the look-at checker.
// Each macro expects clk and arst_n in scope.
`ifndef LOOK_AT_PITCH_YAW_UNIT_MACROS_SVH
`define LOOK_AT_PITCH_YAW_UNIT_MACROS_SVH

// same-cycle implication
`define LAPY_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("%m: assertion failed");

// next-cycle implication
`define LAPY_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("%m: assertion failed");

`endif

// ===== rtl/lapy_pkg.sv =====
// lapy_pkg: widths, angle constants, arctangent table and sideband flag type
// shared by the look-at pitch/yaw pipeline. No dependencies.
package lapy_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int NUM_ITER      = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

	localparam int COORD_W     = 32;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int WORK_SHIFT  = 24;
	localparam int CORD_W      = DIFF_W + WORK_SHIFT + 5;
	localparam int ANG_W       = 32;
	localparam int GAIN_W      = 26;
	localparam int PROD_W      = DIFF_W + GAIN_W;
	localparam int ROUND_SHIFT = 14;
	localparam int RND_W       = ANG_W + 1 - ROUND_SHIFT;
	localparam int PITCH_W     = 18;
	localparam int YAW_W       = 20;

	localparam int HALF_PI_Q16 = 102944;
	localparam int PI_Q16      = 205887;
	localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);

	// CORDIC gain, Q24
	localparam logic signed [GAIN_W-1:0] GAIN_Q24 = 26'sd27628053;

	// atan(2^-i) in Q30, truncated
	localparam logic signed [ANG_W-1:0] ATAN_Q30 [24] = '{
		32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6,
		32'sh03FEAB76, 32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55,
		32'sh003FFFEA, 32'sh001FFFFD, 32'sh000FFFFF, 32'sh0007FFFF,
		32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF, 32'sh00007FFF,
		32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
		32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F
	};

	typedef struct packed {
		logic zero_all;
		logic dy_zero;
		logic dy_pos;
		logic hz_zero;
		logic dx_zero;
		logic dx_pos;
		logic dz_zero;
		logic dz_pos;
	} flags_t;

endpackage

// ===== rtl/lapy_cordic.sv =====
// lapy_cordic: fully unrolled vectoring CORDIC, one register stage per iteration.
// Uses lapy_pkg for widths, iteration count and the arctangent table.
module lapy_cordic import lapy_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [CORD_W-1:0] in_x,
	input  logic signed [CORD_W-1:0] in_y,
	output logic signed [CORD_W-1:0] out_x,
	output logic signed [ANG_W-1:0]  out_z
);

	logic signed [CORD_W-1:0] x_s [NUM_ITER+1];
	logic signed [CORD_W-1:0] y_s [NUM_ITER];
	logic signed [ANG_W-1:0]  z_s [NUM_ITER+1];

	assign x_s[0] = in_x;
	assign y_s[0] = in_y;
	assign z_s[0] = '0;

	for (genvar gi = 0; gi < NUM_ITER; gi++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[gi][CORD_W-1]) begin
					x_s[gi+1] <= x_s[gi] + (y_s[gi] >>> gi);
					z_s[gi+1] <= z_s[gi] + ATAN_Q30[gi];
				end else begin
					x_s[gi+1] <= x_s[gi] - (y_s[gi] >>> gi);
					z_s[gi+1] <= z_s[gi] - ATAN_Q30[gi];
				end
			end
		end

		// residual y is not needed after the last iteration
		if (gi < NUM_ITER - 1) begin : g_y
			always_ff @(posedge clk) begin
				if (en) begin
					if (!y_s[gi][CORD_W-1]) begin
						y_s[gi+1] <= y_s[gi] - (x_s[gi] >>> gi);
					end else begin
						y_s[gi+1] <= y_s[gi] + (x_s[gi] >>> gi);
					end
				end
			end
		end
	end

	assign out_x = x_s[NUM_ITER];
	assign out_z = z_s[NUM_ITER];

endmodule

// ===== rtl/look_at_pitch_yaw_unit.sv =====
// Look-at pitch/yaw unit: takes a position and a target point (signed Q16.16)
// and returns pitch and yaw of position - target in Q16.16 radians, or
// updated = 0 when the two points coincide. Fully pipelined: one request is
// taken every cycle while in_stall is low. Each request passes the difference
// and operand registers, then two CORDIC vectoring chains in series
// (horizontal magnitude, then pitch; yaw runs alongside the first), then the
// rounding register and the output register. A two-entry output register and
// skid stage keep the input open while one result waits to be taken.
// Depends on lapy_pkg and lapy_cordic.
module look_at_pitch_yaw_unit import lapy_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] target_x,
	input  logic signed [COORD_W-1:0] target_y,
	input  logic signed [COORD_W-1:0] target_z,
	input  logic signed [COORD_W-1:0] cam_x,
	input  logic signed [COORD_W-1:0] cam_y,
	input  logic signed [COORD_W-1:0] cam_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      updated,
	output logic signed [PITCH_W-1:0] pitch_angle,
	output logic signed [YAW_W-1:0]   yaw_angle
);

	function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] v);
		return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
	endfunction

	function automatic logic signed [RND_W-1:0] q30_round(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W:0] t;
		t = (ANG_W+1)'(a) + (ANG_W+1)'(ROUND_BIAS);
		return RND_W'(t >>> ROUND_SHIFT);
	endfunction

	function automatic logic signed [PITCH_W-1:0] clamp_q16(input logic signed [RND_W-1:0] r);
		if (r > RND_W'(HALF_PI_Q16))
			return PITCH_W'(HALF_PI_Q16);
		if (r < RND_W'(-HALF_PI_Q16))
			return PITCH_W'(-HALF_PI_Q16);
		return PITCH_W'(r);
	endfunction

	logic en;
	logic skid_valid_q;

	// stage 1: differences
	logic                     v_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;

	// stage 2: flags, CORDIC operands, scaled dy
	logic                     v_s2;
	flags_t                   flg_s2;
	logic signed [CORD_W-1:0] pa_x_s2, pa_y_s2, ya_x_s2, ya_y_s2;
	logic signed [PROD_W-1:0] prod_s2;

	flags_t                   flg_c;
	logic [DIFF_W-1:0]        abs_dx, abs_dz;
	logic signed [DIFF_W:0]   yaw_yin;

	// first CORDIC lane sideband
	logic                     v_sa    [NUM_ITER];
	flags_t                   flg_sa  [NUM_ITER];
	logic signed [PROD_W-1:0] prod_sa [NUM_ITER];

	// second CORDIC lane sideband
	logic                     v_sb    [NUM_ITER];
	flags_t                   flg_sb  [NUM_ITER];
	logic signed [ANG_W-1:0]  yz_sb   [NUM_ITER];

	logic signed [CORD_W-1:0] pa_mag;
	logic signed [ANG_W-1:0]  pa_z_unused_n, ya_z, pb_z;
	logic signed [CORD_W-1:0] ya_x_unused_n, pb_x_unused_n;
	logic signed [CORD_W-1:0] pb_y_in;

	// stage 3: rounded angles
	logic                     v_s3;
	flags_t                   flg_s3;
	logic signed [RND_W-1:0]  pr_s3, yr_s3;

	logic signed [PITCH_W-1:0] pitch_f, yaw_base;
	logic signed [YAW_W-1:0]   yaw_f;

	logic                      p_fire, take, out_free;
	logic                      out_valid_q, out_upd_q, skid_upd_q;
	logic signed [PITCH_W-1:0] out_pitch_q, skid_pitch_q;
	logic signed [YAW_W-1:0]   out_yaw_q, skid_yaw_q;

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int i = 0; i < NUM_ITER; i++) begin
				v_sa[i] <= 1'b0;
				v_sb[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			v_sa[0] <= v_s2;
			v_sb[0] <= v_sa[NUM_ITER-1];
			for (int i = 1; i < NUM_ITER; i++) begin
				v_sa[i] <= v_sa[i-1];
				v_sb[i] <= v_sb[i-1];
			end
			v_s3 <= v_sb[NUM_ITER-1];
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DIFF_W'(cam_x) - DIFF_W'(target_x);
			dy_s1 <= DIFF_W'(cam_y) - DIFF_W'(target_y);
			dz_s1 <= DIFF_W'(cam_z) - DIFF_W'(target_z);
		end
	end

	// ---------------- stage 2 ----------------
	always_comb begin
		flg_c.dx_zero  = (dx_s1 == '0);
		flg_c.dy_zero  = (dy_s1 == '0);
		flg_c.dz_zero  = (dz_s1 == '0);
		flg_c.dx_pos   = !dx_s1[DIFF_W-1] && !flg_c.dx_zero;
		flg_c.dy_pos   = !dy_s1[DIFF_W-1] && !flg_c.dy_zero;
		flg_c.dz_pos   = !dz_s1[DIFF_W-1] && !flg_c.dz_zero;
		flg_c.hz_zero  = flg_c.dx_zero && flg_c.dz_zero;
		flg_c.zero_all = flg_c.hz_zero && flg_c.dy_zero;
	end

	assign abs_dx  = abs_diff(dx_s1);
	assign abs_dz  = abs_diff(dz_s1);
	// yaw operand is dx, negated unless dz is positive
	assign yaw_yin = flg_c.dz_pos ? (DIFF_W+1)'(dx_s1) : -((DIFF_W+1)'(dx_s1));

	always_ff @(posedge clk) begin
		if (en) begin
			flg_s2  <= flg_c;
			pa_x_s2 <= CORD_W'({abs_dx, {WORK_SHIFT{1'b0}}});
			pa_y_s2 <= CORD_W'({abs_dz, {WORK_SHIFT{1'b0}}});
			ya_x_s2 <= CORD_W'({abs_dz, {WORK_SHIFT{1'b0}}});
			ya_y_s2 <= CORD_W'($signed({yaw_yin, {WORK_SHIFT{1'b0}}}));
			prod_s2 <= PROD_W'(dy_s1) * PROD_W'(GAIN_Q24);
		end
	end

	// ---------------- first lane: horizontal magnitude and yaw ----------------
	lapy_cordic u_mag (
		.clk   (clk),
		.en    (en),
		.in_x  (pa_x_s2),
		.in_y  (pa_y_s2),
		.out_x (pa_mag),
		.out_z (pa_z_unused_n)
	);

	lapy_cordic u_yaw (
		.clk   (clk),
		.en    (en),
		.in_x  (ya_x_s2),
		.in_y  (ya_y_s2),
		.out_x (ya_x_unused_n),
		.out_z (ya_z)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			flg_sa[0]  <= flg_s2;
			prod_sa[0] <= prod_s2;
			flg_sb[0]  <= flg_sa[NUM_ITER-1];
			yz_sb[0]   <= ya_z;
			for (int i = 1; i < NUM_ITER; i++) begin
				flg_sa[i]  <= flg_sa[i-1];
				prod_sa[i] <= prod_sa[i-1];
				flg_sb[i]  <= flg_sb[i-1];
				yz_sb[i]   <= yz_sb[i-1];
			end
		end
	end

	// ---------------- second lane: pitch ----------------
	assign pb_y_in = CORD_W'(prod_sa[NUM_ITER-1]);

	lapy_cordic u_pitch (
		.clk   (clk),
		.en    (en),
		.in_x  (pa_mag),
		.in_y  (pb_y_in),
		.out_x (pb_x_unused_n),
		.out_z (pb_z)
	);

	// ---------------- stage 3: rounding ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			flg_s3 <= flg_sb[NUM_ITER-1];
			pr_s3  <= q30_round(pb_z);
			yr_s3  <= q30_round(yz_sb[NUM_ITER-1]);
		end
	end

	// clamp and special cases; a coincident pair lands on zeros through dx/dy flags
	always_comb begin
		if (flg_s3.dy_zero)
			pitch_f = '0;
		else if (flg_s3.hz_zero)
			pitch_f = flg_s3.dy_pos ? PITCH_W'(HALF_PI_Q16) : PITCH_W'(-HALF_PI_Q16);
		else
			pitch_f = clamp_q16(pr_s3);

		if (flg_s3.dx_zero)
			yaw_base = '0;
		else if (flg_s3.dz_zero)
			yaw_base = flg_s3.dx_pos ? PITCH_W'(HALF_PI_Q16) : PITCH_W'(-HALF_PI_Q16);
		else
			yaw_base = clamp_q16(yr_s3);

		yaw_f = YAW_W'(yaw_base) + (flg_s3.dz_pos ? YAW_W'(PI_Q16) : YAW_W'(0));
	end

	// ---------------- output register and skid ----------------
	assign p_fire   = en && v_s3;
	assign take     = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || p_fire;
			skid_valid_q <= 1'b0;
		end else if (p_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_upd_q   <= skid_upd_q;
				out_pitch_q <= skid_pitch_q;
				out_yaw_q   <= skid_yaw_q;
			end else begin
				out_upd_q   <= !flg_s3.zero_all;
				out_pitch_q <= pitch_f;
				out_yaw_q   <= yaw_f;
			end
		end else if (p_fire) begin
			skid_upd_q   <= !flg_s3.zero_all;
			skid_pitch_q <= pitch_f;
			skid_yaw_q   <= yaw_f;
		end
	end

	assign out_valid   = out_valid_q;
	assign updated     = out_upd_q;
	assign pitch_angle = out_pitch_q;
	assign yaw_angle   = out_yaw_q;

endmodule

// ===== rtl/lapy_checker.sv =====
// lapy_checker: port-level assertions for look_at_pitch_yaw_unit, bound to it below.
// Depends on lapy_pkg and look_at_pitch_yaw_unit_macros.svh.
`include "look_at_pitch_yaw_unit_macros.svh"

module lapy_checker import lapy_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic signed [COORD_W-1:0] target_x,
	input logic signed [COORD_W-1:0] target_y,
	input logic signed [COORD_W-1:0] target_z,
	input logic signed [COORD_W-1:0] cam_x,
	input logic signed [COORD_W-1:0] cam_y,
	input logic signed [COORD_W-1:0] cam_z,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic                      updated,
	input logic signed [PITCH_W-1:0] pitch_angle,
	input logic signed [YAW_W-1:0]   yaw_angle
);

	// a stalled result request stays offered
	`LAPY_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// and keeps its payload
	`LAPY_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
		$stable(updated) && $stable(pitch_angle) && $stable(yaw_angle))

	// no update means both angles are zero
	`LAPY_ASSERT_NOW(a_no_update_zero, out_valid && !updated,
		pitch_angle == '0 && yaw_angle == '0)

	// pitch never leaves the clamp range
	`LAPY_ASSERT_NOW(a_pitch_range, out_valid,
		pitch_angle <= PITCH_W'(HALF_PI_Q16) && pitch_angle >= PITCH_W'(-HALF_PI_Q16))

endmodule

bind look_at_pitch_yaw_unit lapy_checker u_lapy_checker (.*);

// ===== tb/tb.sv =====
// tb: self-checking bench for look_at_pitch_yaw_unit; predicts pitch and yaw with an
// in-bench CORDIC vectoring model and checks every result in order.
// Depends on lapy_pkg and the look_at_pitch_yaw_unit RTL.
`timescale 1ns / 100ps

module tb;
	import lapy_pkg::*;

	localparam int ANGLE_STAGES = (lapy_pkg::CORDIC_STAGES > 24) ? 24 : lapy_pkg::CORDIC_STAGES;
	localparam longint Q16_HALF_PI = 102944;
	localparam longint Q16_PI = 205887;
	localparam longint MAG_GAIN = 27628053;
	localparam longint VEC_SCALE = 64'sd1 << 24;
	localparam int DRAIN_CYCLES = 2 * ANGLE_STAGES + 24;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
	localparam logic [31:0] MINV = 32'h8000_0000;

	typedef struct packed {
		logic               updated;
		logic [PITCH_W-1:0] pitch;
		logic [YAW_W-1:0]   yaw;
	} look_angles_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [COORD_W-1:0] target_x = '0;
	logic [COORD_W-1:0] target_y = '0;
	logic [COORD_W-1:0] target_z = '0;
	logic [COORD_W-1:0] cam_x = '0;
	logic [COORD_W-1:0] cam_y = '0;
	logic [COORD_W-1:0] cam_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic updated;
	logic signed [PITCH_W-1:0] pitch_angle;
	logic signed [YAW_W-1:0] yaw_angle;

	longint arctan_q30 [24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
		64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	look_angles_t expected_angles [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	bit sender_idle = 1'b1;
	bit receiver_idle = 1'b1;
	int stall_left = 0;

	look_at_pitch_yaw_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.target_x(target_x),
		.target_y(target_y),
		.target_z(target_z),
		.cam_x(cam_x),
		.cam_y(cam_y),
		.cam_z(cam_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.updated(updated),
		.pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// vectoring CORDIC: drives y to zero, returns the Q30 angle and the scaled magnitude
	function automatic longint vector_angle(input longint x_in, input longint y_in,
			output longint magnitude);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		x = x_in;
		y = y_in;
		z = 0;
		for (int i = 0; i < ANGLE_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + arctan_q30[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - arctan_q30[i];
			end
		end
		magnitude = x;
		return z;
	endfunction

	// Q30 -> Q16 with round-half-up, clamped to +-pi/2
	function automatic longint round_angle(input longint a);
		longint r;
		r = (a + 64'sd8192) >>> 14;
		if (r > Q16_HALF_PI)
			r = Q16_HALF_PI;
		if (r < -Q16_HALF_PI)
			r = -Q16_HALF_PI;
		return r;
	endfunction

	function automatic longint magnitude_of(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic look_angles_t predict_look_angles(input logic [31:0] tx, ty, tz,
			cx, cy, cz);
		look_angles_t res;
		longint dx;
		longint dy;
		longint dz;
		longint pitch;
		longint yaw;
		longint horiz;
		longint unused_mag;
		longint unused_ang;
		dx = longint'($signed(cx)) - longint'($signed(tx));
		dy = longint'($signed(cy)) - longint'($signed(ty));
		dz = longint'($signed(cz)) - longint'($signed(tz));
		pitch = 0;
		yaw = 0;
		res = '0;
		if (dx == 0 && dy == 0 && dz == 0)
			return res;
		if (dy != 0) begin
			if (dx == 0 && dz == 0) begin
				pitch = (dy > 0) ? Q16_HALF_PI : -Q16_HALF_PI;
			end else begin
				unused_ang = vector_angle(magnitude_of(dx) * VEC_SCALE,
					magnitude_of(dz) * VEC_SCALE, horiz);
				pitch = round_angle(vector_angle(horiz, dy * MAG_GAIN, unused_mag));
			end
		end
		if (dx != 0) begin
			if (dz == 0) begin
				yaw = (dx > 0) ? Q16_HALF_PI : -Q16_HALF_PI;
			end else begin
				yaw = round_angle(vector_angle(magnitude_of(dz) * VEC_SCALE,
					((dz > 0) ? dx : -dx) * VEC_SCALE, unused_mag));
			end
		end
		if (dz > 0)
			yaw = yaw + Q16_PI;
		res.updated = 1'b1;
		res.pitch = pitch[PITCH_W-1:0];
		res.yaw = yaw[YAW_W-1:0];
		return res;
	endfunction

	// mostly back-to-back, some short gaps, the odd long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] random_offset();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: begin
				if (r[31])
					return -32'($urandom_range(1, 255));
				return 32'($urandom_range(1, 255));
			end
			2: return {{16{r[31]}}, r[15:0]};
			3: return r;
			default: begin
				case (r[1:0])
					2'd0: return MAXV;
					2'd1: return MINV;
					2'd2: return 32'd1;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	function automatic logic [31:0] random_coord();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? MAXV : MINV;
		return $urandom;
	endfunction

	task automatic send_request(input logic [31:0] tx, ty, tz, cx, cy, cz);
		int gap;
		in_valid <= 1'b1;
		target_x <= tx;
		target_y <= ty;
		target_z <= tz;
		cam_x <= cx;
		cam_y <= cy;
		cam_z <= cz;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_angles.push_back(predict_look_angles(tx, ty, tz, cx, cy, cz));
		gap = sender_idle ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// target random, position a random offset away on each axis (wraps at 32 bits)
	task automatic send_near_request();
		logic [31:0] tx;
		logic [31:0] ty;
		logic [31:0] tz;
		tx = random_coord();
		ty = random_coord();
		tz = random_coord();
		send_request(tx, ty, tz, tx + random_offset(), ty + random_offset(),
			tz + random_offset());
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_angles.size() != 0);
	endtask

	task automatic test_directed_cases();
		// coincident points
		send_request(0, 0, 0, 0, 0, 0);
		send_request(MINV, MINV, MINV, MINV, MINV, MINV);
		send_request(MAXV, MINV, 32'd12345, MAXV, MINV, 32'd12345);
		// straight up and down, full range
		send_request(5, MINV, 7, 5, MAXV, 7);
		send_request(5, MAXV, 7, 5, MINV, 7);
		send_request(0, 0, 0, 0, 1, 0);
		send_request(0, 0, 0, 0, 32'hFFFF_FFFF, 0);
		// level, no height difference
		send_request(0, 0, 0, 1, 0, 1);
		send_request(0, 0, 0, -32'd5, 0, 3);
		// dx zero, dz either side
		send_request(0, 0, 0, 0, 3, 32'h0001_0000);
		send_request(0, 0, 0, 0, 3, 32'hFFFF_0000);
		// dz zero, dx either side
		send_request(0, 0, 0, 32'h0002_0000, -32'd9, 0);
		send_request(0, 0, 0, 32'hFFFE_0000, 32'd9, 0);
		// largest differences on every axis, then mixed large and small differences
		send_request(MINV, MINV, MINV, MAXV, MAXV, MAXV);
		send_request(MAXV, MAXV, MAXV, MINV, MINV, MINV);
		send_request(MINV, 0, MAXV, MAXV, 32'd1, MINV);
		send_request(0, 0, MINV, 1, 0, MAXV);
		send_request(0, MINV, 0, 1, MAXV, 0);
		send_request(MINV, 0, MINV, MAXV, 1, MAXV);
		send_request(0, 0, 0, 32'hFFF0_0000, 32'h0003_8000, 32'h0010_0000);
		send_request(0, 0, 0, 32'h0010_0000, 32'hFFFC_8000, 32'hFFF0_0000);
		send_request(0, 0, 0, MAXV, MINV, MAXV);
	endtask

	task automatic test_random_positions();
		repeat (500)
			send_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic test_near_positions();
		repeat (700)
			send_near_request();
	endtask

	// sender holds off mid-stream until the pipe is empty, then resumes
	task automatic test_drain_then_resume();
		repeat (150)
			send_near_request();
		wait_for_drain();
		repeat (150)
			send_near_request();
	endtask

	task automatic test_back_to_back();
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		repeat (250) begin
			if ($urandom_range(0, 1))
				send_near_request();
			else
				send_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		end
		// full-rate sender against a stalling receiver
		receiver_idle = 1'b1;
		repeat (250)
			send_near_request();
		sender_idle = 1'b1;
	endtask

	always @(posedge clk) begin : receiver_stall
		int n;
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			out_stall <= 1'b1;
		end else if (receiver_idle) begin
			n = pick_gap();
			out_stall <= (n != 0);
			if (n != 0)
				stall_left = n - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		look_angles_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_angles.size() == 0) begin
				$display("%0t: unexpected result updated=%0b pitch=%0d yaw=%0d", $time,
					updated, pitch_angle, yaw_angle);
				mismatch_count++;
			end else begin
				want = expected_angles.pop_front();
				if (updated !== want.updated) begin
					$display("%0t: updated expected %0b, got %0b", $time, want.updated,
						updated);
					mismatch_count++;
				end
				if (pitch_angle !== want.pitch) begin
					$display("%0t: pitch_angle expected %0d, got %0d", $time,
						$signed(want.pitch), pitch_angle);
					mismatch_count++;
				end
				if (yaw_angle !== want.yaw) begin
					$display("%0t: yaw_angle expected %0d, got %0d", $time,
						$signed(want.yaw), yaw_angle);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_positions();
		test_near_positions();
		test_drain_then_resume();
		test_back_to_back();
		wait_for_drain();
		// catch any stray result still in the pipe
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lapy_pkg.sv
rtl/lapy_cordic.sv
rtl/look_at_pitch_yaw_unit.sv
rtl/lapy_checker.sv
tb/tb.sv
